/* rtl/core/sdta_pkg.sv */
// ----------------------------------------------------------------------------
// sdta_pkg: shared types and constants for the integer-to-decimal converter
// Holds the field widths, ASCII codes, BCD geometry and the sequencer types.
// ----------------------------------------------------------------------------
package sdta_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 7;
   localparam int DIGITS     = 10;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = DIGITS * DIGIT_W;
   localparam int STEP_W     = $clog2(VALUE_W);
   localparam int PTR_W      = $clog2(DIGITS);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
   localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;
   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(VALUE_W - 1);

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dabble_status_type;

endpackage

/* rtl/core/sdta_dabble.sv */
// ----------------------------------------------------------------------------
// sdta_dabble: iterative binary-to-BCD converter
// Shift-and-add-3 over one bit per cycle; one load runs VALUE_W steps and
// pulses done. The BCD result holds until the next load.
// ----------------------------------------------------------------------------
module sdta_dabble (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [sdta_pkg::VALUE_W-1:0]     load_value,
   output sdta_pkg::dabble_status_type      status,
   output logic [sdta_pkg::BCD_W-1:0]       bcd
);
   import sdta_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adjusted;
   logic [STEP_W-1:0]  count_ff, count_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   // Adjust every BCD digit of five or more before the shift
   always_comb begin
      digit_type d;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[i*DIGIT_W +: DIGIT_W];
         adjusted[i*DIGIT_W +: DIGIT_W] = (d >= ADJ_LIMIT) ? d + ADJ_ADD : d;
      end
   end

   // Load, then shift one binary bit into the BCD word per cycle
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (load) begin
         bin_in   = load_value;
         bcd_in   = '0;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         bin_in   = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {adjusted[BCD_W-2:0], bin_ff[VALUE_W-1]};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

/* rtl/core/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: 32-bit signed integer to decimal ASCII text
// Sequence: the accepting edge loads the BCD converter, which runs its
// shift-and-add-3 steps and pulses done; the characters then follow at one
// character per cycle (sign, then digits, most significant first). busy stays
// high from acceptance through the last character, so a new value is taken
// only once the previous text is out. Characters appear for one cycle each on
// rsp_valid and cannot be stalled. Synchronous reset returns the sequencer to
// idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sdta_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   output logic [sdta_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                 rsp_last
);
   import sdta_pkg::*;

   state_type          state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               accept;
   logic [VALUE_W-1:0] magnitude;
   dabble_status_type  conv_status;
   logic [BCD_W-1:0]   bcd;
   digit_type          digits [DIGITS];
   logic [PTR_W-1:0]   msd;

   assign accept = start && (state_ff == ST_IDLE);

   // Form the unsigned magnitude; the most negative value maps to itself
   assign magnitude = req_value[VALUE_W-1] ? (~req_value + 1'b1) : req_value;

   sdta_dabble u_dabble (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_value (magnitude),
      .status     (conv_status),
      .bcd        (bcd)
   );

   // Split the BCD word and locate the most significant nonzero digit
   always_comb begin
      msd = '0;
      for (int i = 0; i < DIGITS; i++) begin
         digits[i] = bcd[i*DIGIT_W +: DIGIT_W];
         if (digits[i] != '0) begin
            msd = PTR_W'(i);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      ptr_in   = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONVERT;
               neg_in   = req_value[VALUE_W-1];
            end
         end
         ST_CONVERT: begin
            if (conv_status.done) begin
               ptr_in   = msd;
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            // Hold the pointer on the last digit so it stays in range
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: one character transfer per cycle in the sign and digit states
   always_comb begin
      busy          = 1'b1;
      rsp_valid     = 1'b0;
      rsp_character = CHAR_ZERO + CHAR_W'(digits[ptr_ff]);
      rsp_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_CONVERT: begin
            busy = 1'b1;
         end
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_character = CHAR_MINUS;
         end
         ST_DIGITS: begin
            rsp_valid = 1'b1;
            rsp_last  = (ptr_ff == '0);
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff <= neg_in;
      ptr_ff <= ptr_in;
   end

endmodule

/* tb/sv/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii: self-checking bench for the decimal converter
// Sends 32-bit signed values through the start/busy handshake. A local model
// builds the expected ASCII text of each value, and a checker compares every
// strobed character and last flag with it in order.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
   import sdta_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              is_last;
   } text_char_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [CHAR_W-1:0]          rsp_character;
   logic                       rsp_last;

   text_char_type pending_text[$];
   int            error_count     = 0;
   int            values_sent     = 0;
   int            negatives_sent  = 0;
   int            chars_checked   = 0;
   int            quiet_cycles    = 0;
   bit            sender_gaps_on  = 1'b1;
   bit            prior_pending   = 1'b0;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #1 clock = ~clock;

   // Build the expected text of one value: sign, then digits most significant first
   function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] magnitude;
      logic [DIGIT_W-1:0] digit_list[DIGITS];
      int                 digit_count;
      text_char_type      entry;
      magnitude   = value[VALUE_W-1] ? (~value + 32'd1) : value;
      digit_count = 0;
      do begin
         digit_list[digit_count] = DIGIT_W'(magnitude % 10);
         magnitude = magnitude / 10;
         digit_count++;
      end while (magnitude != 0 && digit_count < DIGITS);
      if (value[VALUE_W-1]) begin
         entry.character = CHAR_MINUS;
         entry.is_last   = 1'b0;
         pending_text.push_back(entry);
      end
      for (int k = digit_count - 1; k >= 0; k--) begin
         entry.character = CHAR_ZERO + CHAR_W'(digit_list[k]);
         entry.is_last   = (k == 0);
         pending_text.push_back(entry);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // Transfer one value; optionally idle first so gaps land in every phase
   task automatic send_value(input logic signed [VALUE_W-1:0] value);
      int mode;
      int gap;
      mode = sender_gaps_on ? $urandom_range(0, 9) : 0;
      gap  = $urandom_range(1, 19);
      if (mode >= 4) begin
         start     <= 1'b0;
         req_value <= $urandom;
         if (mode >= 8 && prior_pending) begin
            // hold off until the previous text starts coming out
            do @(posedge clock); while (!rsp_valid);
         end else if (mode >= 6) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      predict_decimal_text(value);
      prior_pending = 1'b1;
      values_sent++;
      if (value < 0) negatives_sent++;
   endtask

   // Pick a value whose magnitude has exactly n_digits decimal digits
   function automatic logic signed [VALUE_W-1:0] value_with_digits(input int n_digits,
                                                                   input bit negative);
      longint lo;
      longint hi;
      longint magnitude;
      lo = 1;
      for (int k = 1; k < n_digits; k++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (n_digits == 1) lo = 0;
      if (n_digits == DIGITS) hi = negative ? 64'd2147483648 : 64'd2147483647;
      magnitude = $urandom_range(32'(hi), 32'(lo));
      return VALUE_W'(negative ? -magnitude : magnitude);
   endfunction

   task automatic test_extremes();
      logic signed [VALUE_W-1:0] corner_values[$];
      corner_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -987654321,
                        999999999, -999999999, 1000000000, -1000000000, 1234567890,
                        2147483647, -2147483647, 32'sh8000_0000, 32'sh5555_5555,
                        32'shAAAA_AAAA, -2};
      foreach (corner_values[i]) send_value(corner_values[i]);
   endtask

   task automatic test_digit_lengths();
      for (int n = 1; n <= DIGITS; n++) begin
         for (int rep = 0; rep < 4; rep++) send_value(value_with_digits(n, rep[0]));
      end
   endtask

   task automatic test_random_values();
      int pick;
      for (int i = 0; i < 130; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 10)
            send_value($urandom);
         else if (pick < 17)
            send_value(value_with_digits($urandom_range(1, DIGITS),
                                         1'($urandom_range(0, 1))));
         else
            send_value($signed($urandom_range(40)) - 20);
      end
   endtask

   task automatic test_back_to_back();
      sender_gaps_on = 1'b0;
      for (int i = 0; i < 30; i++) begin
         if (i[0])
            send_value($urandom);
         else
            send_value(value_with_digits($urandom_range(1, DIGITS),
                                         1'($urandom_range(0, 1))));
      end
   endtask

   // Compare each strobed character with the oldest expected one
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid) begin
         chars_checked++;
         if (pending_text.size() == 0) begin
            report_mismatch($sformatf("unexpected character %0d last=%0b",
                                      rsp_character, rsp_last));
         end else begin
            want = pending_text.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("character %0d, expected %0d",
                                         rsp_character, want.character));
            if (rsp_last !== want.is_last)
               report_mismatch($sformatf("last %0b, expected %0b on character %0d",
                                         rsp_last, want.is_last, want.character));
         end
      end
   end

   // End the run if neither side transfers anything for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TIMEOUT: no transfer for %0d cycles", QUIET_LIMIT);
         $display("signed_int_to_decimal_ascii verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_digit_lengths();
      test_random_values();
      test_back_to_back();
      start <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d values (%0d negative), %0d characters checked, %0d errors.",
               values_sent, negatives_sent, chars_checked, error_count);
      $display("Covered sign extremes, every digit count, random values and idle gaps.");
      if (error_count == 0) begin
         $display("signed_int_to_decimal_ascii verification clean");
      end else begin
         $display("signed_int_to_decimal_ascii verification failed");
      end
      $finish;
   end

endmodule

/* signed_int_to_decimal_ascii.f */
rtl/core/sdta_pkg.sv
rtl/core/sdta_dabble.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/sv/tb_signed_int_to_decimal_ascii.sv
